// File: rtl/core/sne_pkg.sv
// Shared constants, types and the Laplacian kernel function of the stereo noise estimator.
package sne_pkg;

    // Field and register widths
    localparam int PIX_W        = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int SIGMA_W      = 18;
    localparam int SUM_W        = 32;
    localparam int ABS_W        = 11;
    localparam int LINE_W       = 4 * PIX_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    // Reset sizes and default maxima
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int MIN_SIZE       = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Shared multiplier and scaling
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int PROD_SHIFT = 22;
    // sqrt(pi/2) in Q30 is below 2^31, so the product stays below 2^63
    localparam int DIVIDEND_W = PROD_W - 1 - PROD_SHIFT;
    localparam logic [MUL_W-1:0] SQRT_HALF_PI_Q30 = 32'd1345735807;
    localparam logic [MUL_W-1:0] AREA_SCALE       = 32'd6;

    // Divider status handed back to the sequencer
    typedef struct packed {
        logic               done;
        logic [SIGMA_W-1:0] sigma;
    } t_div_result;

    // Absolute response of [1,-2,1;-2,4,-2;1,-2,1]; columns c-2, c-1 and current
    function automatic logic [ABS_W-1:0] abs_laplace(
        input logic [PIX_W-1:0] c0_top,
        input logic [PIX_W-1:0] c0_mid,
        input logic [PIX_W-1:0] c0_bot,
        input logic [PIX_W-1:0] c1_top,
        input logic [PIX_W-1:0] c1_mid,
        input logic [PIX_W-1:0] c1_bot,
        input logic [PIX_W-1:0] top,
        input logic [PIX_W-1:0] mid,
        input logic [PIX_W-1:0] bot
    );
        logic [ABS_W-1:0] pos;
        logic [ABS_W-1:0] neg;
        pos = ABS_W'(c0_top) + ABS_W'(c0_bot) + ABS_W'(top) + ABS_W'(bot)
            + ABS_W'({c1_mid, 2'b00});
        neg = ABS_W'({c0_mid, 1'b0}) + ABS_W'({c1_top, 1'b0})
            + ABS_W'({c1_bot, 1'b0}) + ABS_W'({mid, 1'b0});
        return (pos >= neg) ? (pos - neg) : (neg - pos);
    endfunction

endpackage

// File: rtl/core/stereo_image_noise_estimator_core.sv
// Stereo noise estimator top level: sequencer, windows, sums and frame-end scaling.
// Each pixel beat passes the accept, left kernel and right kernel states on one shared kernel unit.
// The last pixel of a frame adds 3 passes through the shared multiplier and a bit-serial
// divide before the sigma beat shows.
// The next pixel is taken once the result sits in the output register.
// Synchronous active-low reset: idle, counters and sums cleared, size 640 x 480.
module stereo_image_noise_estimator_core #(
    parameter int MAX_WIDTH  = sne_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sne_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sne_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sne_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sne_pkg::PIX_W-1:0]      i_left_pixel,
    input  logic [sne_pkg::PIX_W-1:0]      i_right_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sne_pkg::SIGMA_W-1:0]    o_noise_sigma
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
    localparam int DEN_W = WD_W + HD_W + 3;
    localparam int PIX_W = sne_pkg::PIX_W;
    localparam int SUM_W = sne_pkg::SUM_W;
    localparam int MUL_W = sne_pkg::MUL_W;

    localparam int RST_WD = (sne_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : sne_pkg::WIDTH_RESET;
    localparam int RST_HD = (sne_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : sne_pkg::HEIGHT_RESET;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_LEFT      = 4'd1;
    localparam logic [3:0] ST_RIGHT     = 4'd2;
    localparam logic [3:0] ST_MUL_AREA  = 4'd3;
    localparam logic [3:0] ST_MUL_SIX   = 4'd4;
    localparam logic [3:0] ST_MUL_GAIN  = 4'd5;
    localparam logic [3:0] ST_DIV_START = 4'd6;
    localparam logic [3:0] ST_DIV       = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    logic [3:0]                  r_state;
    logic [3:0]                  n_state;
    logic [COL_W-1:0]            r_col;
    logic [ROW_W-1:0]            r_row;
    logic [WD_W-1:0]             r_wd;
    logic [HD_W-1:0]             r_hd;
    logic [PIX_W-1:0]            r_pix_l;
    logic [PIX_W-1:0]            r_pix_r;
    logic [5:0][PIX_W-1:0]       r_win_l;
    logic [5:0][PIX_W-1:0]       r_win_r;
    logic [SUM_W-1:0]            r_sum_l;
    logic [SUM_W-1:0]            r_sum_r;
    logic [DEN_W-1:0]            r_den;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [sne_pkg::SIGMA_W-1:0] r_sigma;

    logic                        cfg_we;
    logic                        cfg_hit;
    logic [WD_W-1:0]             cfg_wd;
    logic [HD_W-1:0]             cfg_hd;
    logic                        in_take;
    logic                        is_left;
    logic                        interior;
    logic                        last_col;
    logic                        last_row;
    logic                        out_load;

    logic [sne_pkg::LINE_W-1:0]  line_rd;
    logic [sne_pkg::LINE_W-1:0]  line_wr;
    logic [5:0][PIX_W-1:0]       k_win;
    logic [PIX_W-1:0]            k_top;
    logic [PIX_W-1:0]            k_mid;
    logic [PIX_W-1:0]            k_bot;
    logic [sne_pkg::ABS_W-1:0]   k_abs;
    logic [SUM_W-1:0]            k_sum;
    logic [SUM_W:0]              k_acc;
    logic [SUM_W-1:0]            k_acc_sat;
    logic [5:0][PIX_W-1:0]       k_win_next;
    logic [SUM_W-1:0]            sum_max;

    logic                        mul_en;
    logic [MUL_W-1:0]            mul_a;
    logic [MUL_W-1:0]            mul_b;
    logic [sne_pkg::PROD_W-1:0]  mul_prod;
    logic                        div_start;
    sne_pkg::t_div_result        div_res;

    // Handshakes
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_stall     = (r_state != ST_IDLE) || i_cfg_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign in_take     = i_valid && !o_stall;

    // Decode register writes and clamp sizes into range
    always_comb begin
        cfg_hit = 1'b0;
        unique case (i_cfg_index)
            sne_pkg::REG_WIDTH:  cfg_hit = cfg_we;
            sne_pkg::REG_HEIGHT: cfg_hit = cfg_we;
            default:             cfg_hit = 1'b0;
        endcase
        if (i_cfg_data < sne_pkg::CFG_DATA_W'(sne_pkg::MIN_SIZE)) begin
            cfg_wd = WD_W'(sne_pkg::MIN_SIZE);
            cfg_hd = HD_W'(sne_pkg::MIN_SIZE);
        end else begin
            cfg_wd = (i_cfg_data > MAX_WIDTH)  ? WD_W'(MAX_WIDTH)  : WD_W'(i_cfg_data);
            cfg_hd = (i_cfg_data > MAX_HEIGHT) ? HD_W'(MAX_HEIGHT) : HD_W'(i_cfg_data);
        end
    end

    // Raster position
    assign interior = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign last_col = (WD_W'(r_col) == (r_wd - WD_W'(1)));
    assign last_row = (HD_W'(r_row) == (r_hd - HD_W'(1)));

    // Shared kernel unit: left image in one cycle, right image in the next
    assign is_left    = (r_state == ST_LEFT);
    assign k_win      = is_left ? r_win_l : r_win_r;
    assign k_top      = is_left ? line_rd[31:24] : line_rd[15:8];
    assign k_mid      = is_left ? line_rd[23:16] : line_rd[7:0];
    assign k_bot      = is_left ? r_pix_l : r_pix_r;
    assign k_abs      = sne_pkg::abs_laplace(k_win[0], k_win[1], k_win[2],
                                             k_win[3], k_win[4], k_win[5],
                                             k_top, k_mid, k_bot);
    assign k_sum      = is_left ? r_sum_l : r_sum_r;
    assign k_acc      = {1'b0, k_sum} + (SUM_W + 1)'(k_abs);
    assign k_acc_sat  = k_acc[SUM_W] ? '1 : k_acc[SUM_W-1:0];
    assign k_win_next = {k_bot, k_mid, k_top, k_win[5], k_win[4], k_win[3]};

    // Line store entry: left r-2, left r-1, right r-2, right r-1
    assign line_wr = {line_rd[23:16], r_pix_l, line_rd[7:0], r_pix_r};

    sne_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_RIGHT),
        .i_waddr (r_col),
        .i_wdata (line_wr),
        .i_raddr (r_col),
        .o_rdata (line_rd)
    );

    // Shared multiplier operands: area, times six, then gain
    assign sum_max = (r_sum_l > r_sum_r) ? r_sum_l : r_sum_r;
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_MUL_AREA: begin
                mul_a = MUL_W'(r_wd - WD_W'(2));
                mul_b = MUL_W'(r_hd - HD_W'(2));
            end
            ST_MUL_SIX: begin
                mul_a = mul_prod[MUL_W-1:0];
                mul_b = sne_pkg::AREA_SCALE;
            end
            ST_MUL_GAIN: begin
                mul_a = sum_max;
                mul_b = sne_pkg::SQRT_HALF_PI_Q30;
            end
            default: mul_en = 1'b0;
        endcase
    end

    sne_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign div_start = (r_state == ST_DIV_START);

    sne_div #(
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod[sne_pkg::PROD_SHIFT +: sne_pkg::DIVIDEND_W]),
        .i_divisor  (r_den),
        .o_result   (div_res)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_take) n_state = ST_LEFT;
            ST_LEFT:      n_state = ST_RIGHT;
            ST_RIGHT:     n_state = (last_col && last_row) ? ST_MUL_AREA : ST_IDLE;
            ST_MUL_AREA:  n_state = ST_MUL_SIX;
            ST_MUL_SIX:   n_state = ST_MUL_GAIN;
            ST_MUL_GAIN:  n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV;
            ST_DIV:       if (div_res.done) n_state = ST_DONE;
            ST_DONE:      if (out_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Output register: load when empty or being emptied
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign n_out_valid = out_load || (r_out_valid && i_stall);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_wd        <= WD_W'(RST_WD);
            r_hd        <= HD_W'(RST_HD);
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            // Take a size and restart the frame
            if (cfg_we && (i_cfg_index == sne_pkg::REG_WIDTH)) begin
                r_wd <= cfg_wd;
            end
            if (cfg_we && (i_cfg_index == sne_pkg::REG_HEIGHT)) begin
                r_hd <= cfg_hd;
            end
            if (cfg_hit) begin
                r_col   <= '0;
                r_row   <= '0;
                r_sum_l <= '0;
                r_sum_r <= '0;
            end else begin
                // Advance the raster position
                if (r_state == ST_RIGHT) begin
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= last_row ? '0 : (r_row + ROW_W'(1));
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                // Accumulate interior responses, drop the sums once scaled
                if (r_state == ST_MUL_GAIN) begin
                    r_sum_l <= '0;
                    r_sum_r <= '0;
                end else if (interior && (r_state == ST_LEFT)) begin
                    r_sum_l <= k_acc_sat;
                end else if (interior && (r_state == ST_RIGHT)) begin
                    r_sum_r <= k_acc_sat;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pix_l <= i_left_pixel;
            r_pix_r <= i_right_pixel;
        end
        if (r_state == ST_LEFT) begin
            r_win_l <= k_win_next;
        end
        if (r_state == ST_RIGHT) begin
            r_win_r <= k_win_next;
        end
        if (r_state == ST_MUL_GAIN) begin
            r_den <= mul_prod[DEN_W-1:0];
        end
        if (out_load) begin
            r_sigma <= div_res.sigma;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_noise_sigma = r_sigma;

endmodule

// File: rtl/core/sne_line_store.sv
// Two-row line store for both images, one write and one registered read per cycle.
module sne_line_store #(
    parameter int DEPTH = sne_pkg::MAX_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [sne_pkg::LINE_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [sne_pkg::LINE_W-1:0] o_rdata
);

    logic [sne_pkg::LINE_W-1:0] r_mem [DEPTH];
    logic [sne_pkg::LINE_W-1:0] r_rdata;

    // Write one column entry, read one column entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sne_mul.sv
// Shared 32x32 multiplier with a registered product.
module sne_mul (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [sne_pkg::MUL_W-1:0]  i_a,
    input  logic [sne_pkg::MUL_W-1:0]  i_b,
    output logic [sne_pkg::PROD_W-1:0] o_prod
);

    logic [sne_pkg::PROD_W-1:0] r_prod;

    // Hold the product until the next operand pair
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= sne_pkg::PROD_W'(i_a) * sne_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/sne_div.sv
// Restoring divider, one quotient bit per cycle, with a saturated sigma result.
module sne_div #(
    parameter int DEN_W = 27
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sne_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [DEN_W-1:0]               i_divisor,
    output sne_pkg::t_div_result           o_result
);

    localparam int NUM_W = sne_pkg::DIVIDEND_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic             over;

    // Trial subtraction of one step
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift dividend bits into the remainder, quotient bits out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    // Saturate to the sigma range
    assign over           = |r_quot[NUM_W-1:sne_pkg::SIGMA_W];
    assign o_result.done  = r_done;
    assign o_result.sigma = over ? '1 : r_quot[sne_pkg::SIGMA_W-1:0];

endmodule

// File: rtl/core/sne_checker.sv
// Port-level checker for the stereo noise estimator and its bind to the top level.
module sne_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [sne_pkg::SIGMA_W-1:0] o_noise_sigma
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_sigma))
        else $error("result beat changed while stalled");

    // An accepted pixel keeps the block busy in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !o_cfg_ready)
        else $error("block free right after taking a pixel");

    // Without a register write pending, pixel and register sides agree on idle
    a_idle_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |-> (o_cfg_ready != o_stall))
        else $error("pixel and register ports disagree on idle");

    // A new result only comes out of a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without preceding work");

endmodule

bind stereo_image_noise_estimator_core sne_checker u_sne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_noise_sigma (o_noise_sigma)
);

// File: test/tb.sv
// Self-checking testbench for the stereo image noise estimator core.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_W          = sne_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H          = sne_pkg::MAX_HEIGHT_DEF;
    localparam int PIX_W          = sne_pkg::PIX_W;
    localparam int SUM_W          = sne_pkg::SUM_W;
    localparam int SIGMA_W        = sne_pkg::SIGMA_W;
    localparam int CFG_IDX_W      = sne_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = sne_pkg::CFG_DATA_W;
    localparam int MIN_SIZE       = sne_pkg::MIN_SIZE;
    // Frame-end scaling: sqrt(pi/2) in Q30, the kernel gain of 6 and the Q10.8 alignment
    localparam longint unsigned ROOT_HALF_PI_Q30 = 64'd1345735807;
    localparam longint unsigned KERNEL_GAIN      = 64'd6;
    localparam int              SIGMA_ALIGN      = 22;
    localparam longint unsigned SIGMA_CEIL       = (64'd1 << SIGMA_W) - 1;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PRESSURE_HOLD  = 700;
    localparam int WATCHDOG_NS    = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE = '1;

    typedef enum {PAT_RANDOM, PAT_NOISY, PAT_FLAT, PAT_CHECKER, PAT_EXTREME} t_pattern;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_left_pixel  = '0;
    logic [PIX_W-1:0]      i_right_pixel = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [SIGMA_W-1:0]    o_noise_sigma;

    stereo_image_noise_estimator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_left_pixel  (i_left_pixel),
        .i_right_pixel (i_right_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_noise_sigma (o_noise_sigma)
    );

    // Predicted state: index 0 is the left image, 1 the right
    bit [PIX_W-1:0]      row_above  [0:1][0:MAX_W-1];
    bit [PIX_W-1:0]      row_above2 [0:1][0:MAX_W-1];
    bit [PIX_W-1:0]      nbhd       [0:1][0:5];
    bit [SUM_W-1:0]      abs_sum    [0:1];
    int unsigned         pix_col;
    int unsigned         pix_row;
    bit [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(sne_pkg::WIDTH_RESET);
    bit [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(sne_pkg::HEIGHT_RESET);

    bit [SIGMA_W-1:0] sigma_expected_q[$];
    bit [SIGMA_W-1:0] sigma_wanted;

    int sender_gap_pct    = 0;
    int receiver_hold_pct = 0;
    int hold_left         = 0;
    int error_count       = 0;
    int pixels_sent       = 0;
    int sigmas_checked    = 0;
    int reg_writes        = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("%0t: timeout, %0d sigma beats still awaited", $time, sigma_expected_q.size());
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned clamp_size(bit [CFG_DATA_W-1:0] v, int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Add the absolute kernel response of an interior pixel to a sum and slide that image's window
    function automatic void take_pixel(int side, bit [PIX_W-1:0] pix, int unsigned c,
                                       int unsigned r);
        int          top;
        int          mid;
        int          resp;
        bit [SUM_W:0] total;
        top = row_above2[side][c];
        mid = row_above[side][c];
        if (r >= 2 && c >= 2) begin
            resp = (int'(nbhd[side][0]) - 2 * int'(nbhd[side][1]) + int'(nbhd[side][2]))
                 - 2 * (int'(nbhd[side][3]) - 2 * int'(nbhd[side][4]) + int'(nbhd[side][5]))
                 + (top - 2 * mid + int'(pix));
            if (resp < 0) resp = -resp;
            total = {1'b0, abs_sum[side]} + (SUM_W + 1)'(resp);
            abs_sum[side] = total[SUM_W] ? '1 : total[SUM_W-1:0];
        end
        nbhd[side][0] = nbhd[side][3];
        nbhd[side][1] = nbhd[side][4];
        nbhd[side][2] = nbhd[side][5];
        nbhd[side][3] = top[PIX_W-1:0];
        nbhd[side][4] = mid[PIX_W-1:0];
        nbhd[side][5] = pix;
        row_above2[side][c] = mid[PIX_W-1:0];
        row_above[side][c]  = pix;
    endfunction

    // Advance the raster position; at the last pixel queue the frame's sigma
    function automatic void predict_sigma(bit [PIX_W-1:0] left_pix, bit [PIX_W-1:0] right_pix);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        longint unsigned larger;
        longint unsigned area;
        longint unsigned q;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        c = (pix_col >= w) ? w - 1 : pix_col;
        r = (pix_row >= h) ? h - 1 : pix_row;
        take_pixel(0, left_pix, c, r);
        take_pixel(1, right_pix, c, r);
        if (c + 1 < w) begin
            pix_col = c + 1;
            pix_row = r;
            return;
        end
        pix_col = 0;
        if (r + 1 < h) begin
            pix_row = r + 1;
            return;
        end
        larger = (abs_sum[0] > abs_sum[1]) ? abs_sum[0] : abs_sum[1];
        area   = KERNEL_GAIN * longint'(w - 2) * longint'(h - 2);
        q      = (larger * ROOT_HALF_PI_Q30) / (area << SIGMA_ALIGN);
        if (q > SIGMA_CEIL) q = SIGMA_CEIL;
        sigma_expected_q.insert(sigma_expected_q.size(), q[SIGMA_W-1:0]);
        pix_row    = 0;
        abs_sum[0] = '0;
        abs_sum[1] = '0;
    endfunction

    function automatic bit [PIX_W-1:0] pattern_pixel(t_pattern pat, int unsigned row_i,
                                                     int unsigned col_i, bit [PIX_W-1:0] level,
                                                     bit inv);
        int v;
        case (pat)
            PAT_FLAT: v = level;
            PAT_NOISY: begin
                v = int'(level) + int'($urandom_range(6)) - 3;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            // centre and corners high, edges low (the reverse when inverted): the largest kernel response
            PAT_CHECKER: v = (((row_i + col_i) & 1) ^ inv) ? 0 : 255;
            PAT_EXTREME: v = $urandom_range(1) ? 255 : 0;
            default: v = $urandom_range(255);
        endcase
        return v[PIX_W-1:0];
    endfunction

    // Offer one pixel beat and hold it until the block takes it
    task automatic send_pixel(input bit [PIX_W-1:0] left_pix, input bit [PIX_W-1:0] right_pix);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_left_pixel  <= left_pix;
        i_right_pixel <= right_pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_sigma(left_pix, right_pix);
        pixels_sent++;
    endtask

    // Drop valid, collect every awaited sigma, then let the pipeline empty
    task automatic settle_block;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sigma_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] value);
        settle_block();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        // a known register restarts the frame; a spare index is ignored
        if (idx == sne_pkg::REG_WIDTH || idx == sne_pkg::REG_HEIGHT) begin
            if (idx == sne_pkg::REG_WIDTH) width_reg = value;
            else height_reg = value;
            pix_col    = 0;
            pix_row    = 0;
            abs_sum[0] = '0;
            abs_sum[1] = '0;
        end
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input bit [CFG_DATA_W-1:0] w, input bit [CFG_DATA_W-1:0] h);
        write_reg(sne_pkg::REG_WIDTH, w);
        write_reg(sne_pkg::REG_HEIGHT, h);
    endtask

    task automatic run_frame(input t_pattern left_pat, input t_pattern right_pat,
                             input bit [PIX_W-1:0] left_level, input bit [PIX_W-1:0] right_level,
                             input bit left_inv, input bit right_inv, input int unsigned count);
        int unsigned w;
        int unsigned idx;
        w = clamp_size(width_reg, MAX_W);
        for (idx = 0; idx < count; idx++) begin
            send_pixel(pattern_pixel(left_pat, idx / w, idx % w, left_level, left_inv),
                       pattern_pixel(right_pat, idx / w, idx % w, right_level, right_inv));
        end
    endtask

    // Largest positive and negative responses, each winning on its own side, and flat images
    task automatic test_kernel_extremes;
        sender_gap_pct    = 23;
        receiver_hold_pct = 59;
        set_size(CFG_DATA_W'(MIN_SIZE), CFG_DATA_W'(MIN_SIZE));
        run_frame(PAT_CHECKER, PAT_NOISY, 8'd0, 8'd128, 1'b0, 1'b0, 9);
        run_frame(PAT_NOISY, PAT_CHECKER, 8'd0, 8'd0, 1'b0, 1'b1, 9);
        run_frame(PAT_FLAT, PAT_FLAT, 8'd255, 8'd0, 1'b0, 1'b0, 9);
    endtask

    // A register write mid-frame restarts it; a write to a spare index does not
    task automatic test_frame_restart;
        set_size(11'd4, 11'd4);
        run_frame(PAT_RANDOM, PAT_RANDOM, 8'd0, 8'd0, 1'b0, 1'b0, 7);
        write_reg(sne_pkg::REG_HEIGHT, 11'd4);
        run_frame(PAT_RANDOM, PAT_RANDOM, 8'd0, 8'd0, 1'b0, 1'b0, 16);
        run_frame(PAT_RANDOM, PAT_RANDOM, 8'd0, 8'd0, 1'b0, 1'b0, 5);
        write_reg(CFG_IDX_W'($urandom_range(REG_LAST_SPARE, sne_pkg::REG_HEIGHT + 1)),
                  CFG_DATA_W'($urandom_range(2047)));
        run_frame(PAT_RANDOM, PAT_RANDOM, 8'd0, 8'd0, 1'b0, 1'b0, 11);
    endtask

    // Sizes below the minimum on either register, and on both at once
    task automatic test_size_clamping;
        set_size(11'd0, 11'd2);
        run_frame(PAT_RANDOM, PAT_RANDOM, 8'd0, 8'd0, 1'b0, 1'b0, 9);
        set_size(11'd1, 11'd5);
        run_frame(PAT_RANDOM, PAT_NOISY, 8'd0, 8'd200, 1'b0, 1'b0, 15);
        set_size(11'd6, 11'd0);
        run_frame(PAT_NOISY, PAT_EXTREME, 8'd60, 8'd0, 1'b0, 1'b0, 18);
    endtask

    // Hold the output off for a long stretch so the block fills and stalls its input
    task automatic test_input_backpressure;
        sender_gap_pct    = 0;
        receiver_hold_pct = 0;
        set_size(CFG_DATA_W'(MIN_SIZE), CFG_DATA_W'(MIN_SIZE));
        @(posedge i_clk);
        hold_left = PRESSURE_HOLD;
        run_frame(PAT_RANDOM, PAT_EXTREME, 8'd0, 8'd0, 1'b0, 1'b0, 63);
    endtask

    // Mostly whole frames of small random size and content, some cut short by a restart
    task automatic test_random_frames;
        int          phase;
        int          pick;
        int unsigned goal;
        int unsigned area;
        int unsigned cut;
        for (phase = 0; phase < 3; phase++) begin
            sender_gap_pct    = (phase == 0) ? 23 : (phase == 1) ? 59 : 0;
            receiver_hold_pct = (phase == 0) ? 59 : (phase == 1) ? 23 : 0;
            goal = pixels_sent + 340;
            while (pixels_sent < goal) begin
                if ($urandom_range(99) < 40) begin
                    pick = $urandom_range(99);
                    if (pick < 88)
                        set_size(CFG_DATA_W'($urandom_range(8, 3)),
                                 CFG_DATA_W'($urandom_range(5, 3)));
                    else if (pick < 97)
                        set_size(CFG_DATA_W'($urandom_range(40, 9)),
                                 CFG_DATA_W'($urandom_range(8, 3)));
                    else
                        set_size(CFG_DATA_W'($urandom_range(2)),
                                 CFG_DATA_W'($urandom_range(2)));
                end
                area = clamp_size(width_reg, MAX_W) * clamp_size(height_reg, MAX_H);
                cut  = ($urandom_range(99) < 10) ? $urandom_range(area - 1, 1) : area;
                run_frame(($urandom_range(1) ? PAT_RANDOM : t_pattern'($urandom_range(4))),
                          ($urandom_range(1) ? PAT_RANDOM : t_pattern'($urandom_range(4))),
                          PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), cut);
                if (cut < area)
                    write_reg($urandom_range(1) ? sne_pkg::REG_WIDTH : sne_pkg::REG_HEIGHT,
                              CFG_DATA_W'($urandom_range(8, 3)));
            end
        end
    endtask

    // Receiver: random stall, or a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < receiver_hold_pct);
            end
        end
    end

    // Compare each accepted sigma beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (sigma_expected_q.size() == 0) begin
                $display("%0t: sigma beat %0d arrived with none expected", $time, o_noise_sigma);
                error_count++;
            end else begin
                sigma_wanted = sigma_expected_q.pop_front();
                sigmas_checked++;
                if (o_noise_sigma !== sigma_wanted) begin
                    $display("%0t: noise_sigma expected %0d, got %0d", $time, sigma_wanted,
                             o_noise_sigma);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_kernel_extremes();
        test_frame_restart();
        test_size_clamping();
        test_input_backpressure();
        test_random_frames();

        settle_block();
        $display("Streamed %0d pixel beats over %0d register writes: kernel extremes, restarts,",
                 pixels_sent, reg_writes);
        $display("size clamping, output hold-off and random frames; %0d sigmas, %0d mismatches.",
                 sigmas_checked, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
